// ===== rtl/fsv_pkg.sv =====
// Shared types and constants for the field serializer.
`timescale 1ns / 1ps

package fsv_pkg;

    // Data path widths
    localparam int WORD_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int VAR_GRP = 7;
    localparam int CNT_W   = 4;

    // Format codes carried on the operation field
    typedef enum logic [3:0] {
        OP_BYTE   = 4'd0,
        OP_BOOL   = 4'd1,
        OP_U16_BE = 4'd2,
        OP_U16_LE = 4'd3,
        OP_U32_BE = 4'd4,
        OP_U32_LE = 4'd5,
        OP_U64_BE = 4'd6,
        OP_U64_LE = 4'd7,
        OP_UVAR32 = 4'd8,
        OP_SVAR32 = 4'd9,
        OP_UVAR64 = 4'd10,
        OP_SVAR64 = 4'd11
    } t_op;

    // Load command from the format decoder to the shift unit
    typedef struct packed {
        logic              ok;      // known format, request produces bytes
        logic              varint;  // 7-bit groups with continuation flag
        logic [CNT_W-1:0]  nbytes;  // byte count of a fixed-width format
        logic [WORD_W-1:0] word;    // value arranged so the first byte is lowest
    } t_load;

    // Sequencer controls for the shift unit
    typedef struct packed {
        logic load;
        logic step;
    } t_shift_ctl;

endpackage

// ===== rtl/fsv_format.sv =====
// Format decoder: masks, zigzag-maps and byte-orders the value for the shift unit.
`timescale 1ns / 1ps

module fsv_format
    import fsv_pkg::*;
(
    input  logic [3:0]        i_operation,
    input  logic [WORD_W-1:0] i_value,
    output t_load             o_load
);

    logic [WORD_W-1:0] be64;
    logic [31:0]       zz32;
    logic [WORD_W-1:0] zz64;

    // Byte reversal of the full word for big-endian 64
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            be64[BYTE_W*i +: BYTE_W] = i_value[BYTE_W*(7-i) +: BYTE_W];
        end
    end

    // Zigzag maps, left shift wraps
    assign zz32 = {i_value[30:0], 1'b0} ^ {32{i_value[31]}};
    assign zz64 = {i_value[62:0], 1'b0} ^ {WORD_W{i_value[63]}};

    // Decode the format code into a load command
    always_comb begin
        o_load.ok     = 1'b1;
        o_load.varint = 1'b0;
        o_load.nbytes = CNT_W'(1);
        o_load.word   = '0;
        unique case (t_op'(i_operation))
            OP_BYTE: begin
                o_load.word = {56'b0, i_value[7:0]};
            end
            OP_BOOL: begin
                o_load.word = {63'b0, |i_value};
            end
            OP_U16_BE: begin
                o_load.nbytes = CNT_W'(2);
                o_load.word   = {48'b0, i_value[7:0], i_value[15:8]};
            end
            OP_U16_LE: begin
                o_load.nbytes = CNT_W'(2);
                o_load.word   = {48'b0, i_value[15:0]};
            end
            OP_U32_BE: begin
                o_load.nbytes = CNT_W'(4);
                o_load.word   = {32'b0, i_value[7:0], i_value[15:8],
                                 i_value[23:16], i_value[31:24]};
            end
            OP_U32_LE: begin
                o_load.nbytes = CNT_W'(4);
                o_load.word   = {32'b0, i_value[31:0]};
            end
            OP_U64_BE: begin
                o_load.nbytes = CNT_W'(8);
                o_load.word   = be64;
            end
            OP_U64_LE: begin
                o_load.nbytes = CNT_W'(8);
                o_load.word   = i_value;
            end
            OP_UVAR32: begin
                o_load.varint = 1'b1;
                o_load.word   = {32'b0, i_value[31:0]};
            end
            OP_SVAR32: begin
                o_load.varint = 1'b1;
                o_load.word   = {32'b0, zz32};
            end
            OP_UVAR64: begin
                o_load.varint = 1'b1;
                o_load.word   = i_value;
            end
            OP_SVAR64: begin
                o_load.varint = 1'b1;
                o_load.word   = zz64;
            end
            default: begin
                // unused codes: request dropped
                o_load.ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/fsv_shift_unit.sv =====
// Shared shift unit: holds the word and peels off one output byte per step.
`timescale 1ns / 1ps

module fsv_shift_unit
    import fsv_pkg::*;
(
    input  logic        i_clk,
    input  t_shift_ctl  i_ctl,
    input  t_load       i_load,
    output logic [7:0]  o_byte,
    output logic        o_last
);

    logic [WORD_W-1:0] r_word, n_word;
    logic              r_varint, n_varint;
    logic [CNT_W-1:0]  r_left, n_left;

    // Last byte: varint when no upper groups remain, fixed when one byte is left
    assign o_last = r_varint ? (r_word[WORD_W-1:VAR_GRP] == '0)
                             : (r_left == CNT_W'(1));
    assign o_byte = r_varint ? {~o_last, r_word[VAR_GRP-1:0]} : r_word[BYTE_W-1:0];

    // Load or shift by one group
    always_comb begin
        n_word   = r_word;
        n_varint = r_varint;
        n_left   = r_left;
        if (i_ctl.load) begin
            n_word   = i_load.word;
            n_varint = i_load.varint;
            n_left   = i_load.nbytes;
        end else if (i_ctl.step) begin
            n_word = r_varint ? (r_word >> VAR_GRP) : (r_word >> BYTE_W);
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_varint <= n_varint;
        r_left   <= n_left;
    end

endmodule

// ===== rtl/field_serializer_varint_endian.sv =====
// Field serializer top level: handshake sequencer around the format decoder and shift unit.
// Latency: the first byte is valid the cycle after a request is accepted.
// Throughput: one byte per cycle while the sink is ready; a request of n bytes
//   (1 to 10) holds the block until its last byte is taken, as there is a single shift unit.
// Unused format codes are accepted and dropped with no bytes.
// Reset: synchronous, active low; returns to idle and drops any byte in flight.
`timescale 1ns / 1ps

module field_serializer_varint_endian
    import fsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_operation,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state     r_state, n_state;
    t_load      load;
    t_shift_ctl ctl;
    logic       in_fire;
    logic       out_fire;

    fsv_format u_format (
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_load      (load)
    );

    fsv_shift_unit u_shift (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_load (load),
        .o_byte (o_out_byte),
        .o_last (o_last)
    );

    // Handshakes
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = (r_state == ST_SEND);
    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    assign ctl.load = in_fire && load.ok;
    assign ctl.step = out_fire;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && load.ok) n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_fire && o_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // Never taking a request while bytes are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("request taken while bytes pending");

    // Last byte taken returns the block to idle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_last) |=> o_ready)
        else $error("block not idle after last byte");

    // Dropped codes produce no bytes
    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !load.ok) |=> (o_ready && !o_valid))
        else $error("unused code produced output");

    // A known code always starts output
    a_start_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && load.ok) |=> o_valid)
        else $error("accepted request produced no output");
`endif

endmodule
